>>> design/tcw_pkg.sv
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

  // Request codes on in_req_type
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] ATTR_RESET   = 8'h07;

  // Microprogram step addresses
  typedef logic [3:0] step_t;
  localparam step_t S_INIT   = 4'd0;
  localparam step_t S_INIT_Z = 4'd1;
  localparam step_t S_FETCH  = 4'd2;
  localparam step_t S_DISP   = 4'd3;
  localparam step_t S_CHAR   = 4'd4;
  localparam step_t S_NL     = 4'd5;
  localparam step_t S_CHK    = 4'd6;
  localparam step_t S_SCR0   = 4'd7;
  localparam step_t S_COPY   = 4'd8;
  localparam step_t S_SZERO  = 4'd9;
  localparam step_t S_SFIN   = 4'd10;
  localparam step_t S_RD     = 4'd11;
  localparam step_t S_RDCAP  = 4'd12;
  localparam step_t S_CLR    = 4'd13;
  localparam step_t S_CZERO  = 4'd14;
  localparam step_t S_RESP   = 4'd15;

  typedef enum logic [1:0] {MEM_NONE, MEM_CHAR, MEM_COPY, MEM_ZERO} mem_op_t;
  typedef enum logic [1:0] {RD_IDX, RD_COLS, RD_PTRC} rd_sel_t;
  typedef enum logic [1:0] {PTR_HOLD, PTR_CLR, PTR_INC} ptr_op_t;
  typedef enum logic [2:0] {CUR_HOLD, CUR_ADV, CUR_NL, CUR_SCROLL, CUR_HOME} cur_op_t;
  typedef enum logic [1:0] {HOLD_NONE, HOLD_IN, HOLD_OUT} hold_t;
  typedef enum logic [2:0] {
    BR_NEXT, BR_ALWAYS, BR_PTR_LAST, BR_PTR_COPY, BR_CUR_IN, BR_DISPATCH
  } br_t;

  // One control word
  typedef struct packed {
    mem_op_t mem_op;
    rd_sel_t rd_sel;
    ptr_op_t ptr_op;
    cur_op_t cur_op;
    hold_t   hold;
    br_t     br;
    step_t   target;
    logic    set_scr;
    logic    rd_cap;
  } uc_t;

  localparam uc_t UC_NOP = '{
    mem_op:  MEM_NONE,
    rd_sel:  RD_IDX,
    ptr_op:  PTR_HOLD,
    cur_op:  CUR_HOLD,
    hold:    HOLD_NONE,
    br:      BR_NEXT,
    target:  S_INIT,
    set_scr: 1'b0,
    rd_cap:  1'b0
  };

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic  in_fire;
    logic  out_busy;
    logic  ptr_at_last;
    logic  ptr_at_copy_end;
    logic  cur_in_range;
    step_t disp_step;
  } status_t;

endpackage

`default_nettype wire

>>> design/tcw_useq.sv
// Microprogram ROM and step counter for the text console writer.
`default_nettype none

module tcw_useq (
  input  wire              clk,
  input  wire              rst_n,
  input  wire tcw_pkg::status_t st,
  output tcw_pkg::uc_t     uc
);
  import tcw_pkg::*;

  step_t upc_r, upc_nxt;
  logic  hold_now;
  logic  take;

  // Control store
  always_comb begin
    uc = UC_NOP;
    unique case (upc_r)
      S_INIT: begin
        uc.ptr_op = PTR_CLR;
      end
      S_INIT_Z: begin
        uc.mem_op = MEM_ZERO;
        uc.ptr_op = PTR_INC;
        uc.br     = BR_PTR_LAST;
        uc.target = S_INIT_Z;
      end
      S_FETCH: begin
        uc.hold = HOLD_IN;
      end
      S_DISP: begin
        uc.br = BR_DISPATCH;
      end
      S_CHAR: begin
        uc.mem_op = MEM_CHAR;
        uc.cur_op = CUR_ADV;
        uc.br     = BR_ALWAYS;
        uc.target = S_CHK;
      end
      S_NL: begin
        uc.cur_op = CUR_NL;
      end
      S_CHK: begin
        uc.br     = BR_CUR_IN;
        uc.target = S_RESP;
      end
      S_SCR0: begin
        uc.ptr_op  = PTR_CLR;
        uc.rd_sel  = RD_COLS;
        uc.set_scr = 1'b1;
      end
      S_COPY: begin
        uc.mem_op = MEM_COPY;
        uc.rd_sel = RD_PTRC;
        uc.ptr_op = PTR_INC;
        uc.br     = BR_PTR_COPY;
        uc.target = S_COPY;
      end
      S_SZERO: begin
        uc.mem_op = MEM_ZERO;
        uc.ptr_op = PTR_INC;
        uc.br     = BR_PTR_LAST;
        uc.target = S_SZERO;
      end
      S_SFIN: begin
        uc.cur_op = CUR_SCROLL;
        uc.br     = BR_ALWAYS;
        uc.target = S_RESP;
      end
      S_RD: begin
        uc.rd_sel = RD_IDX;
      end
      S_RDCAP: begin
        uc.rd_cap = 1'b1;
        uc.br     = BR_ALWAYS;
        uc.target = S_RESP;
      end
      S_CLR: begin
        uc.ptr_op = PTR_CLR;
        uc.cur_op = CUR_HOME;
      end
      S_CZERO: begin
        uc.mem_op = MEM_ZERO;
        uc.ptr_op = PTR_INC;
        uc.br     = BR_PTR_LAST;
        uc.target = S_CZERO;
      end
      S_RESP: begin
        uc.hold   = HOLD_OUT;
        uc.br     = BR_ALWAYS;
        uc.target = S_FETCH;
      end
      default: begin
        uc = UC_NOP;
      end
    endcase
  end

  assign hold_now = ((uc.hold == HOLD_IN) && !st.in_fire) ||
                    ((uc.hold == HOLD_OUT) && st.out_busy);

  always_comb begin
    case (uc.br)
      BR_ALWAYS:   take = 1'b1;
      BR_PTR_LAST: take = !st.ptr_at_last;
      BR_PTR_COPY: take = !st.ptr_at_copy_end;
      BR_CUR_IN:   take = st.cur_in_range;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    if (hold_now) begin
      upc_nxt = upc_r;
    end else if (uc.br == BR_DISPATCH) begin
      upc_nxt = st.disp_step;
    end else if (take) begin
      upc_nxt = uc.target;
    end else begin
      upc_nxt = upc_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_INIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/text_console_writer_top.sv
// Top level of the text console writer: cell store, cursor datapath, ports.
`default_nettype none

// Channel  | Ports                                       | Dir | Notes
// ---------+---------------------------------------------+-----+------------------------------
// in       | in_valid/in_ready, in_req_type, in_char_code,| in  | one request word
//          | in_cell_index                               |     |
// out      | out_valid/out_ready, out_cursor_pos,        | out | one result word per request,
//          | out_scrolled, out_read_char, out_read_attr  |     | held in an output register
// cfg      | cfg_valid/cfg_ready, cfg_data               | in  | text attribute, always ready
//
// Steps: a character is written at the cursor or a newline moves it, then the cursor is
//   checked and the result sent; a scroll copies every row up and wipes the last row (one
//   copy or wipe per cycle on the single write port of the cell store), and a clear wipes
//   the whole store; a read fetches and captures one cell.
// Reset: after rst_n the store is wiped one cell a cycle, with in_ready low; cfg writes are
//   taken throughout.
// Stalls: a request may be taken while the previous result still waits; the sequencer parks
//   in its response step until the output register frees.

module text_console_writer_top #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  wire        clk,
  input  wire        rst_n,
  // request channel
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [1:0]  in_req_type,
  input  wire [7:0]  in_char_code,
  input  wire [10:0] in_cell_index,
  // result channel
  output logic       out_valid,
  input  wire        out_ready,
  output logic [10:0] out_cursor_pos,
  output logic       out_scrolled,
  output logic [7:0] out_read_char,
  output logic [7:0] out_read_attr,
  // configuration
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [7:0]  cfg_data
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = ROWS * COLS;
  localparam int AW         = $clog2(CELL_COUNT);      // store address
  localparam int CW         = $clog2(CELL_COUNT + 1);  // cursor may touch CELL_COUNT
  localparam int COLW       = $clog2(COLS);

  localparam logic [AW-1:0] PTR_LAST      = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] PTR_COPY_END  = AW'(CELL_COUNT - COLS - 1);
  localparam logic [CW-1:0] CUR_LAST_ROW  = CW'(CELL_COUNT - COLS);
  localparam logic [CW-1:0] CUR_LIMIT     = CW'(CELL_COUNT);
  localparam logic [CW-1:0] COLS_CW       = CW'(COLS);
  localparam logic [CW-1:0] COLS_P1_CW    = CW'(COLS + 1);
  localparam logic [COLW-1:0] COL_LAST    = COLW'(COLS - 1);

  uc_t     uc;
  status_t st;

  // request word
  logic [1:0]  req_r;
  logic [7:0]  ch_r;
  logic [10:0] idx_r;
  logic        in_fire;

  // cursor and sweep pointer
  logic [CW-1:0]   cursor_r, cursor_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;

  logic [7:0] attr_r;

  // per-request flags
  logic       scr_r;
  logic [7:0] rd_char_r;
  logic [7:0] rd_attr_r;
  logic       idx_ok;

  // cell store: {attribute, character}
  logic [15:0]   cells [CELL_COUNT];
  logic [15:0]   rdata_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          wr_en;

  // output register
  logic        out_busy;
  logic        resp_load;

  step_t disp_step;

  tcw_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .uc    (uc)
  );

  assign in_ready  = (uc.hold == HOLD_IN);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid && !out_ready;
  assign resp_load = (uc.hold == HOLD_OUT) && !out_busy;
  assign idx_ok    = (32'(idx_r) < 32'(CELL_COUNT));

  // Dispatch on the latched request; newline has its own step
  always_comb begin
    unique case (req_r)
      REQ_PUT:   disp_step = (ch_r == NEWLINE_CODE) ? S_NL : S_CHAR;
      REQ_CLEAR: disp_step = S_CLR;
      REQ_READ:  disp_step = S_RD;
      default:   disp_step = S_RESP;  // unused code: report cursor only
    endcase
  end

  always_comb begin
    st.in_fire         = in_fire;
    st.out_busy        = out_busy;
    st.ptr_at_last     = (ptr_r == PTR_LAST);
    st.ptr_at_copy_end = (ptr_r == PTR_COPY_END);
    st.cur_in_range    = (cursor_r < CUR_LIMIT);
    st.disp_step       = disp_step;
  end

  // Cursor: column tracked alongside so a newline needs no modulo
  always_comb begin
    cursor_nxt = cursor_r;
    col_nxt    = col_r;
    case (uc.cur_op)
      CUR_ADV: begin
        cursor_nxt = cursor_r + CW'(1);
        col_nxt    = (col_r == COL_LAST) ? '0 : col_r + COLW'(1);
      end
      CUR_NL: begin
        cursor_nxt = cursor_r + (COLS_CW - CW'(col_r));
        col_nxt    = '0;
      end
      CUR_SCROLL: begin
        cursor_nxt = CUR_LAST_ROW;
        col_nxt    = '0;
      end
      CUR_HOME: begin
        cursor_nxt = '0;
        col_nxt    = '0;
      end
      default: begin
        cursor_nxt = cursor_r;
        col_nxt    = col_r;
      end
    endcase
  end

  always_comb begin
    case (uc.ptr_op)
      PTR_CLR: ptr_nxt = '0;
      PTR_INC: ptr_nxt = ptr_r + AW'(1);
      default: ptr_nxt = ptr_r;
    endcase
  end

  // Store ports. During a scroll the read runs one row ahead of the write,
  // so each copy writes the word fetched in the previous cycle.
  always_comb begin
    case (uc.rd_sel)
      RD_COLS: rd_addr = AW'(COLS);
      RD_PTRC: rd_addr = AW'(CW'(ptr_r) + COLS_P1_CW);
      default: rd_addr = AW'(idx_r);
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = ptr_r;
    wr_data = '0;
    case (uc.mem_op)
      MEM_CHAR: begin
        wr_addr = AW'(cursor_r);
        wr_data = {attr_r, ch_r};
      end
      MEM_COPY: wr_data = rdata_r;
      MEM_ZERO: wr_data = '0;
      default:  wr_en   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells[wr_addr] <= wr_data;
    end
    rdata_r <= cells[rd_addr];
  end

  // Request latch and per-request flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_r     <= 1'b0;
      rd_char_r <= '0;
      rd_attr_r <= '0;
    end else if (in_fire) begin
      scr_r     <= 1'b0;
      rd_char_r <= '0;
      rd_attr_r <= '0;
    end else begin
      if (uc.set_scr) begin
        scr_r <= 1'b1;
      end
      if (uc.rd_cap && idx_ok) begin
        rd_char_r <= rdata_r[7:0];
        rd_attr_r <= rdata_r[15:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_req_type;
      ch_r  <= in_char_code;
      idx_r <= in_cell_index;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      col_r    <= '0;
      ptr_r    <= '0;
      attr_r   <= ATTR_RESET;
    end else begin
      cursor_r <= cursor_nxt;
      col_r    <= col_nxt;
      ptr_r    <= ptr_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (resp_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_cursor_pos <= 11'(cursor_r);
      out_scrolled   <= scr_r;
      out_read_char  <= rd_char_r;
      out_read_attr  <= rd_attr_r;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/text_console_checker.sv
// Checker for the text console writer: shadow screen, expected results, field compare.
module text_console_checker #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [10:0] out_cursor_pos,
  input  logic        out_scrolled,
  input  logic [7:0]  out_read_char,
  input  logic [7:0]  out_read_attr,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          mismatch_count,
  output int          pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int unsigned CELLS = ROWS * COLS;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic        scrolled;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
  } console_result_t;

  // shadow of the cell store: attribute in the high byte, character in the low
  logic [15:0]     shadow_screen [CELLS];
  int unsigned     shadow_cursor;
  logic [7:0]      text_attr;
  console_result_t awaited_results [$];

  initial begin
    mismatch_count = 0;
    pending_words  = 0;
  end

  function automatic void scroll_screen();
    for (int unsigned i = 0; i < CELLS; i++)
      shadow_screen[i] = (i + COLS < CELLS) ? shadow_screen[i + COLS] : 16'h0000;
    shadow_cursor = CELLS - COLS;
  endfunction

  function automatic console_result_t console_response(input logic [1:0] req,
                                                       input logic [7:0] ch,
                                                       input logic [10:0] idx);
    console_result_t res;
    res = '0;
    case (req)
      REQ_PUT: begin
        if (ch == NEWLINE_CODE) begin
          shadow_cursor = (shadow_cursor / COLS + 1) * COLS;
        end else begin
          if (shadow_cursor < CELLS) shadow_screen[shadow_cursor] = {text_attr, ch};
          shadow_cursor++;
        end
        if (shadow_cursor >= CELLS) begin
          scroll_screen();
          res.scrolled = 1'b1;
        end
      end
      REQ_CLEAR: begin
        foreach (shadow_screen[i]) shadow_screen[i] = 16'h0000;
        shadow_cursor = 0;
      end
      REQ_READ: begin
        if (idx < CELLS) {res.read_attr, res.read_char} = shadow_screen[idx];
      end
      default: ; // spare code: no change
    endcase
    res.cursor_pos = shadow_cursor[10:0];
    return res;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    console_result_t want;
    if (!rst_n) begin
      foreach (shadow_screen[i]) shadow_screen[i] = 16'h0000;
      shadow_cursor = 0;
      text_attr     = ATTR_RESET;
      awaited_results.delete();
    end else begin
      // result side first: a word taken at this edge cannot answer this edge
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: unexpected result word, expected none, actual cursor %0d",
                   $time, out_cursor_pos);
        end else begin
          want = awaited_results.pop_front();
          check_field("cursor_pos", want.cursor_pos, out_cursor_pos);
          check_field("scrolled", want.scrolled, out_scrolled);
          check_field("read_char", want.read_char, out_read_char);
          check_field("read_attr", want.read_attr, out_read_attr);
        end
      end
      if (in_valid && in_ready)
        awaited_results.push_back(console_response(in_req_type, in_char_code, in_cell_index));
      if (cfg_valid && cfg_ready) text_attr = cfg_data;
    end
    pending_words = awaited_results.size();
  end

endmodule

>>> tb/sv/text_console_writer_top_test.sv
// Stimulus and verdict for the text console writer, with its checker alongside.
module text_console_writer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int ROWS = 25;
  localparam int COLS = 80;

  // the one request code the block leaves unused
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // cycles with no word moving on any channel before the run is abandoned;
  // the slowest legal gap is a scroll or clear plus the long receiver hold-off, so
  // this leaves a wide margin
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type   = '0;
  logic [7:0]  in_char_code  = '0;
  logic [10:0] in_cell_index = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [10:0] out_cursor_pos;
  logic        out_scrolled;
  logic [7:0]  out_read_char;
  logic [7:0]  out_read_attr;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data      = '0;

  int mismatch_count;
  int pending_words;

  // idling knobs, percentages out of a hundred
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_on   = 1'b0;
  int quiet_cycles = 0;

  text_console_writer_top #(.ROWS(ROWS), .COLS(COLS)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cursor_pos(out_cursor_pos),
    .out_scrolled  (out_scrolled),
    .out_read_char (out_read_char),
    .out_read_attr (out_read_attr),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  text_console_checker #(.ROWS(ROWS), .COLS(COLS)) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cursor_pos(out_cursor_pos),
    .out_scrolled  (out_scrolled),
    .out_read_char (out_read_char),
    .out_read_attr (out_read_attr),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .pending_words (pending_words)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Receiver: decides ready at each falling edge. The long hold-off wins over
  // the random stalls; hold_on only changes at rising edges, so no race here.
  always @(negedge clk)
    out_ready <= !hold_on && ($urandom_range(0, 99) >= stall_pct);

  // Watchdog: counts cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request word. Entered at a falling edge, returns at the falling
  // edge after the word is taken. Valid is left high so that back-to-back
  // words see no gap; the caller drops it when the phase ends.
  task automatic send_word(input logic [1:0] req, input logic [7:0] ch,
                           input logic [10:0] idx);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_char_code  <= ch;
    in_cell_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Attribute write; only called with nothing in flight.
  task automatic write_attribute(input logic [7:0] attr);
    cfg_valid <= 1'b1;
    cfg_data  <= attr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic shaped like console output: runs of text, some ending in a
  // newline, bursts of newlines that drive the cursor to the bottom and keep
  // scrolling, reads over the store, the odd clear, and some raw noise.
  task automatic send_console_traffic(input int words);
    int sent;
    int pick;
    int len;
    int sel;
    logic [7:0]  ch;
    logic [10:0] idx;
    sent = 0;
    while (sent < words) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // text run; now and then long enough to wrap past a row end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 30);
        for (int n = 0; n < len; n++) begin
          ch = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(8'h20, 8'h7E));
          send_word(REQ_PUT, ch, 11'($urandom));
        end
        sent += len;
        if ($urandom_range(0, 1) == 1) begin
          send_word(REQ_PUT, NEWLINE_CODE, 11'($urandom));
          sent++;
        end
      end else if (pick < 55) begin
        len = $urandom_range(1, 8);
        for (int n = 0; n < len; n++) send_word(REQ_PUT, NEWLINE_CODE, 11'($urandom));
        sent += len;
      end else if (pick < 80) begin
        // reads: mostly in range, biased towards the bottom rows where text lands
        len = $urandom_range(1, 6);
        for (int n = 0; n < len; n++) begin
          sel = $urandom_range(0, 9);
          if (sel < 5)      idx = 11'($urandom_range(0, ROWS * COLS - 1));
          else if (sel < 8) idx = 11'($urandom_range((ROWS - 2) * COLS, ROWS * COLS - 1));
          else              idx = 11'($urandom_range(0, 2047));
          send_word(REQ_READ, 8'($urandom), idx);
        end
        sent += len;
      end else if (pick < 83) begin
        send_word(REQ_CLEAR, 8'($urandom), 11'($urandom));
        sent++;
      end else begin
        len = $urandom_range(1, 4);
        for (int n = 0; n < len; n++)
          send_word(2'($urandom), 8'($urandom), 11'($urandom));
        sent += len;
      end
    end
  endtask

  // One phase: drain, set the attribute, set the idling, run traffic.
  task automatic run_phase(input int send_gap, input int recv_gap, input logic [7:0] attr,
                           input bit long_hold, input int words);
    while (pending_words != 0) @(negedge clk);
    write_attribute(attr);
    idle_pct  = send_gap;
    stall_pct = recv_gap;
    if (long_hold) begin
      // receiver holds off for a long stretch while the sender keeps offering,
      // so the output register fills and the block stops taking requests
      fork
        begin
          @(posedge clk);
          hold_on = 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_on = 1'b0;
        end
      join_none
    end
    send_console_traffic(words);
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words, reset attribute, no idling. The first accept only comes
    // once the block has finished wiping its store after reset.
    send_word(REQ_READ, 8'h00, 11'd0);            // empty store reads zero
    send_word(REQ_PUT, 8'h41, 11'd0);
    send_word(REQ_PUT, 8'h00, 11'd0);             // lowest character
    send_word(REQ_PUT, 8'hFF, 11'h7FF);           // highest character
    send_word(REQ_PUT, NEWLINE_CODE, 11'd0);      // mid-row newline
    send_word(REQ_PUT, 8'h7E, 11'd0);
    send_word(REQ_READ, 8'h00, 11'd0);
    send_word(REQ_READ, 8'hFF, 11'd1);
    send_word(REQ_READ, 8'h00, 11'd2);
    send_word(REQ_READ, 8'h00, 11'd80);
    send_word(REQ_READ, 8'h00, 11'd81);
    send_word(REQ_READ, 8'h00, 11'(ROWS * COLS - 1)); // last cell
    send_word(REQ_READ, 8'h00, 11'(ROWS * COLS));     // just past the store
    send_word(REQ_READ, 8'h00, 11'h7FF);              // far past the store
    send_word(REQ_SPARE, 8'hFF, 11'h7FF);         // spare code changes nothing
    send_word(REQ_SPARE, 8'h00, 11'd0);
    send_word(REQ_CLEAR, 8'h00, 11'd0);
    send_word(REQ_READ, 8'h00, 11'd0);            // cleared cell
    send_word(REQ_READ, 8'h00, 11'd80);
    send_word(REQ_PUT, NEWLINE_CODE, 11'd0);      // newline from home
    in_valid <= 1'b0;

    // random phases, each under its own attribute, extremes first
    run_phase(0,  0,  8'hFF, 1'b0, 150);          // no idling
    run_phase(68, 0,  8'h00, 1'b0, 150);          // sender mostly idle
    run_phase(0,  68, 8'($urandom), 1'b0, 150);   // receiver mostly stalling
    run_phase(13, 13, 8'($urandom), 1'b0, 150);   // both, lightly
    run_phase(0,  0,  8'($urandom), 1'b1, 150);   // long receiver hold-off

    // drain; the watchdog bounds this wait if results stop coming
    while (pending_words != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> text_console_writer_top.f
design/tcw_pkg.sv
design/tcw_useq.sv
design/text_console_writer_top.sv
tb/sv/text_console_checker.sv
tb/sv/text_console_writer_top_test.sv
